### rtl/core/ttb_pkg.sv
// Shared widths, word types and component codes for the triangle tangent basis block.
package ttb_pkg;

    // Coordinate format: signed fixed point, COORD_WIDTH bits, FRAC_BITS fraction bits
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Working widths derived from the coordinate format
    localparam int DELTA_W = COORD_WIDTH + 1;          // difference of two coordinates
    localparam int PROD_W  = 2 * DELTA_W;              // product of two differences
    localparam int CROSS_W = PROD_W + 1;               // a*b - c*d, also its magnitude
    localparam int NUM_W   = CROSS_W + FRAC_BITS;      // scaled dividend
    localparam int QUO_W   = COORD_WIDTH + 1;          // quotient bits developed
    localparam int HI_W    = NUM_W - QUO_W;            // dividend bits above the quotient
    localparam int CMP_W   = (HI_W > CROSS_W) ? HI_W : CROSS_W;
    localparam int CNT_W   = $clog2(QUO_W + 1);

    // Vertices per triangle, which is also the number of result copies
    localparam int COPIES = 3;
    localparam int AXES   = 3;

    // Component codes walked by the sequencer
    localparam int            COMP_W       = 3;
    localparam logic [COMP_W-1:0] COMP_TAN_X   = 3'd0;
    localparam logic [COMP_W-1:0] COMP_TAN_Y   = 3'd1;
    localparam logic [COMP_W-1:0] COMP_TAN_Z   = 3'd2;
    localparam logic [COMP_W-1:0] COMP_BITAN_X = 3'd3;
    localparam logic [COMP_W-1:0] COMP_BITAN_Y = 3'd4;
    localparam logic [COMP_W-1:0] COMP_BITAN_Z = 3'd5;
    localparam logic [COMP_W-1:0] COMP_DET     = 3'd6;
    localparam int                NUM_RES      = 6;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic signed [COORD_WIDTH-1:0] tex_u;
        logic signed [COORD_WIDTH-1:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] tan_x;
        logic signed [COORD_WIDTH-1:0] tan_y;
        logic signed [COORD_WIDTH-1:0] tan_z;
        logic signed [COORD_WIDTH-1:0] bitan_x;
        logic signed [COORD_WIDTH-1:0] bitan_y;
        logic signed [COORD_WIDTH-1:0] bitan_z;
        logic                          degenerate;
        logic                          last_of_triangle;
    } basis_t;

endpackage

### rtl/core/triangle_tangent_basis_top.sv
// Triangle tangent basis: stores two vertices, then forms tangent and bitangent on the third.
//
// Vertices enter one word at a time on the vertex channel. The first two vertices of a
// triangle are stored. The third vertex starts the computation: one shared 33x33 signed
// multiplier forms the uv determinant and the six numerators, two products each, and one
// restoring divider yields one quotient bit per cycle. The determinant is formed first and
// each component is then divided by it; a component that saturates early skips the divide
// steps, and a zero determinant goes straight to output. The result is then offered three
// times on the basis channel, the third copy marked last_of_triangle.
// While the copies are offered, the first two vertices of the next triangle are taken;
// its third vertex waits until the last copy has been taken. Results are rounded to
// nearest, ties away from zero, and saturate to the signed coordinate range; a zero
// determinant sets degenerate and gives zero vectors.
module triangle_tangent_basis_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vertex_valid,
    output logic                vertex_ready,
    input  ttb_pkg::vertex_t    vertex,
    output logic                basis_valid,
    input  logic                basis_ready,
    output ttb_pkg::basis_t     basis
);

    localparam int CW = ttb_pkg::COORD_WIDTH;
    localparam int DW = ttb_pkg::DELTA_W;
    localparam int PW = ttb_pkg::PROD_W;
    localparam int XW = ttb_pkg::CROSS_W;
    localparam int QW = ttb_pkg::QUO_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MULA = 4'd1;
    localparam logic [3:0] S_MULB = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_ABS  = 4'd4;
    localparam logic [3:0] S_DIVI = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    // Vertex phase codes
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    localparam logic [QW:0] LIM_NEG = (QW + 1)'(1) << (CW - 1);
    localparam logic [QW:0] LIM_POS = LIM_NEG - (QW + 1)'(1);

    localparam logic [1:0] LAST_COPY = 2'(ttb_pkg::COPIES - 1);

    logic [3:0]                      state_reg, state_next;
    logic [1:0]                      phase_reg, phase_next;
    ttb_pkg::vertex_t                first_reg, first_next;
    ttb_pkg::vertex_t                second_reg, second_next;

    logic signed [DW-1:0]            dp1_reg [ttb_pkg::AXES];
    logic signed [DW-1:0]            dp1_next [ttb_pkg::AXES];
    logic signed [DW-1:0]            dp2_reg [ttb_pkg::AXES];
    logic signed [DW-1:0]            dp2_next [ttb_pkg::AXES];
    logic signed [DW-1:0]            e1u_reg, e1u_next, e1v_reg, e1v_next;
    logic signed [DW-1:0]            e2u_reg, e2u_next, e2v_reg, e2v_next;

    logic [ttb_pkg::COMP_W-1:0]      comp_reg, comp_next;
    logic signed [PW-1:0]            prod_reg, prod_next;
    logic signed [XW-1:0]            acc_reg, acc_next;
    logic [XW-1:0]                   mag_reg, mag_next;
    logic                            num_neg_reg, num_neg_next;
    logic [XW-1:0]                   den_reg, den_next;
    logic                            den_neg_reg, den_neg_next;
    logic                            degen_reg, degen_next;
    logic [XW-1:0]                   rem_reg, rem_next;
    logic [QW-1:0]                   quo_reg, quo_next;
    logic [QW-1:0]                   lo_reg, lo_next;
    logic [ttb_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            sat_reg, sat_next;
    logic signed [CW-1:0]            res_reg [ttb_pkg::NUM_RES];
    logic signed [CW-1:0]            res_next [ttb_pkg::NUM_RES];
    logic [1:0]                      emit_reg, emit_next;

    // Datapath intermediates
    logic signed [DW-1:0]            mul_a, mul_b;
    logic signed [PW-1:0]            mul_p;
    logic [1:0]                      axis;
    logic [ttb_pkg::NUM_W-1:0]       num_ext;
    logic [ttb_pkg::CMP_W-1:0]       hi_cmp, den_cmp;
    logic [XW:0]                     trial, trial_diff;
    logic                            trial_ge, round_up, q_neg;
    logic [QW:0]                     q_round, q_lim, q_mag, q_signed;
    logic                            in_fire, out_fire;

    assign in_fire  = vertex_valid && vertex_ready;
    assign out_fire = basis_valid && basis_ready;

    // Take the first two vertices when idle or while the result is offered; the third only when idle
    assign vertex_ready = (state_reg == S_IDLE) ||
                          ((state_reg == S_EMIT) && (phase_reg != PH_THIRD));

    // Axis of the component being worked on
    always_comb
    begin
        if (comp_reg >= ttb_pkg::COMP_BITAN_X)
        begin
            axis = 2'(comp_reg - ttb_pkg::COMP_BITAN_X);
        end
        else
        begin
            axis = comp_reg[1:0];
        end
    end

    // Select the multiplier operands for the current component and product
    always_comb
    begin
        mul_a = e1u_reg;
        mul_b = e2v_reg;
        case (comp_reg) inside
            ttb_pkg::COMP_DET:
            begin
                mul_a = (state_reg == S_MULA) ? e1u_reg : e1v_reg;
                mul_b = (state_reg == S_MULA) ? e2v_reg : e2u_reg;
            end
            ttb_pkg::COMP_TAN_X, ttb_pkg::COMP_TAN_Y, ttb_pkg::COMP_TAN_Z:
            begin
                mul_a = (state_reg == S_MULA) ? dp1_reg[axis] : dp2_reg[axis];
                mul_b = (state_reg == S_MULA) ? e2v_reg : e1v_reg;
            end
            default:
            begin
                mul_a = (state_reg == S_MULA) ? dp2_reg[axis] : dp1_reg[axis];
                mul_b = (state_reg == S_MULA) ? e1u_reg : e2u_reg;
            end
        endcase
    end

    // Shared multiplier
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Divider set-up: split the scaled dividend into the part above the quotient and the rest
    assign num_ext = {mag_reg, {ttb_pkg::FRAC_BITS{1'b0}}};
    assign hi_cmp  = ttb_pkg::CMP_W'(num_ext[ttb_pkg::NUM_W-1:QW]);
    assign den_cmp = ttb_pkg::CMP_W'(den_reg);

    // One restoring step
    assign trial      = {rem_reg, lo_reg[QW-1]};
    assign trial_ge   = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};

    // Round, saturate and apply the sign
    assign round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};
    assign q_neg    = num_neg_reg ^ den_neg_reg;
    assign q_round  = {1'b0, quo_reg} + (QW + 1)'(round_up);
    assign q_lim    = q_neg ? LIM_NEG : LIM_POS;
    assign q_mag    = (sat_reg || (q_round > q_lim)) ? q_lim : q_round;
    assign q_signed = q_neg ? (QW + 1)'(-q_mag) : q_mag;

    // Next-state logic
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        dp1_next     = dp1_reg;
        dp2_next     = dp2_reg;
        e1u_next     = e1u_reg;
        e1v_next     = e1v_reg;
        e2u_next     = e2u_reg;
        e2v_next     = e2v_reg;
        comp_next    = comp_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        mag_next     = mag_reg;
        num_neg_next = num_neg_reg;
        den_next     = den_reg;
        den_neg_next = den_neg_reg;
        degen_next   = degen_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        lo_next      = lo_reg;
        cnt_next     = cnt_reg;
        sat_next     = sat_reg;
        res_next     = res_reg;
        emit_next    = emit_reg;

        // Store the first two vertices; form all deltas on the third
        if (in_fire)
        begin
            case (phase_reg)
                PH_SECOND:
                begin
                    second_next = vertex;
                    phase_next  = PH_THIRD;
                end
                PH_THIRD:
                begin
                    dp1_next[0] = DW'(second_reg.pos_x) - DW'(first_reg.pos_x);
                    dp1_next[1] = DW'(second_reg.pos_y) - DW'(first_reg.pos_y);
                    dp1_next[2] = DW'(second_reg.pos_z) - DW'(first_reg.pos_z);
                    dp2_next[0] = DW'(vertex.pos_x) - DW'(first_reg.pos_x);
                    dp2_next[1] = DW'(vertex.pos_y) - DW'(first_reg.pos_y);
                    dp2_next[2] = DW'(vertex.pos_z) - DW'(first_reg.pos_z);
                    e1u_next    = DW'(second_reg.tex_u) - DW'(first_reg.tex_u);
                    e1v_next    = DW'(second_reg.tex_v) - DW'(first_reg.tex_v);
                    e2u_next    = DW'(vertex.tex_u) - DW'(first_reg.tex_u);
                    e2v_next    = DW'(vertex.tex_v) - DW'(first_reg.tex_v);
                    phase_next  = PH_FIRST;
                    comp_next   = ttb_pkg::COMP_DET;
                    state_next  = S_MULA;
                end
                default:
                begin
                    first_next = vertex;
                    phase_next = PH_SECOND;
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_MULA:
            begin
                prod_next  = mul_p;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                acc_next   = XW'(prod_reg);
                prod_next  = mul_p;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next   = acc_reg - XW'(prod_reg);
                state_next = S_ABS;
            end
            S_ABS:
            begin
                mag_next     = acc_reg[XW-1] ? XW'(-acc_reg) : XW'(acc_reg);
                num_neg_next = acc_reg[XW-1];
                state_next   = S_DIVI;
            end
            S_DIVI:
            begin
                if (comp_reg == ttb_pkg::COMP_DET)
                begin
                    // Keep the divisor; a zero determinant skips straight to output
                    den_next     = mag_reg;
                    den_neg_next = num_neg_reg;
                    degen_next   = (mag_reg == '0);
                    comp_next    = ttb_pkg::COMP_TAN_X;
                    if (mag_reg == '0)
                    begin
                        for (int i = 0; i < ttb_pkg::NUM_RES; i++)
                        begin
                            res_next[i] = '0;
                        end
                        emit_next  = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_MULA;
                    end
                end
                else
                begin
                    // A quotient past the developed bits saturates without iterating
                    sat_next = hi_cmp >= den_cmp;
                    rem_next = hi_cmp[XW-1:0];
                    lo_next  = num_ext[QW-1:0];
                    quo_next = '0;
                    cnt_next = ttb_pkg::CNT_W'(QW);
                    if (hi_cmp >= den_cmp)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next = trial_ge ? trial_diff[XW-1:0] : trial[XW-1:0];
                quo_next = {quo_reg[QW-2:0], trial_ge};
                lo_next  = {lo_reg[QW-2:0], 1'b0};
                cnt_next = cnt_reg - ttb_pkg::CNT_W'(1);
                if (cnt_reg == ttb_pkg::CNT_W'(1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                res_next[comp_reg] = q_signed[CW-1:0];
                if (comp_reg == ttb_pkg::COMP_BITAN_Z)
                begin
                    emit_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    comp_next  = comp_reg + ttb_pkg::COMP_W'(1);
                    state_next = S_MULA;
                end
            end
            S_EMIT:
            begin
                // Offer the result once per vertex of the triangle
                if (out_fire)
                begin
                    emit_next = emit_reg + 2'd1;
                    if (emit_reg == LAST_COPY)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_FIRST;
            first_reg  <= '0;
            second_reg <= '0;
            emit_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            emit_reg   <= emit_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dp1_reg     <= dp1_next;
        dp2_reg     <= dp2_next;
        e1u_reg     <= e1u_next;
        e1v_reg     <= e1v_next;
        e2u_reg     <= e2u_next;
        e2v_reg     <= e2v_next;
        comp_reg    <= comp_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        mag_reg     <= mag_next;
        num_neg_reg <= num_neg_next;
        den_reg     <= den_next;
        den_neg_reg <= den_neg_next;
        degen_reg   <= degen_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        lo_reg      <= lo_next;
        cnt_reg     <= cnt_next;
        sat_reg     <= sat_next;
        res_reg     <= res_next;
    end

    // Drive the result word from the held registers
    assign basis_valid            = (state_reg == S_EMIT);
    assign basis.tan_x            = res_reg[ttb_pkg::COMP_TAN_X];
    assign basis.tan_y            = res_reg[ttb_pkg::COMP_TAN_Y];
    assign basis.tan_z            = res_reg[ttb_pkg::COMP_TAN_Z];
    assign basis.bitan_x          = res_reg[ttb_pkg::COMP_BITAN_X];
    assign basis.bitan_y          = res_reg[ttb_pkg::COMP_BITAN_Y];
    assign basis.bitan_z          = res_reg[ttb_pkg::COMP_BITAN_Z];
    assign basis.degenerate       = degen_reg;
    assign basis.last_of_triangle = (emit_reg == LAST_COPY);

endmodule
